@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL. They compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// Condition in one cycle implies a property in the next
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: check failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

@@ src/edd_pkg.sv @@
package edd_pkg;

    // Default datapath geometry
    localparam int DEF_SAMPLE_BITS = 12;
    localparam int DEF_FRAC_BITS   = 16;

    // Fixed field widths
    localparam int ALPHA_BITS  = 16;
    localparam int THRESH_BITS = 12;
    localparam int DIPS_BITS   = 16;
    localparam int COUNT_BITS  = 48;
    localparam int SUM_BITS    = 60;

    // Configuration port
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_ADDR_BITS-1:0] REG_ALPHA      = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_THRESHOLD  = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HYSTERESIS = 2'd2;

    localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET      = 16'd6554;
    localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET  = 12'd124;
    localparam logic [THRESH_BITS-1:0] HYSTERESIS_RESET = 12'd37;

    // Per-window dip tracking state
    typedef struct packed {
        logic                 fresh;   // next sample opens a new window
        logic                 in_dip;
        logic [DIPS_BITS-1:0] dips;
    } edd_window_t;

endpackage

@@ src/edd_update.sv @@
module edd_update #(
    parameter int SAMPLE_BITS = edd_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = edd_pkg::DEF_FRAC_BITS
) (
    input  logic [SAMPLE_BITS-1:0]           sample,
    input  logic                             last_of_window,
    input  logic [edd_pkg::ALPHA_BITS-1:0]   alpha,
    input  logic [edd_pkg::THRESH_BITS-1:0]  threshold,
    input  logic [edd_pkg::THRESH_BITS-1:0]  hysteresis,
    input  logic [SAMPLE_BITS+FRAC_BITS-1:0] level,
    input  edd_pkg::edd_window_t             win,
    output logic [SAMPLE_BITS+FRAC_BITS-1:0] level_next,
    output edd_pkg::edd_window_t             win_next
);
    import edd_pkg::*;

    localparam int LEVEL_BITS = SAMPLE_BITS + FRAC_BITS;
    localparam int ACC_W      = LEVEL_BITS + ALPHA_BITS + 2;
    localparam int SUM_W      = ((SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS) + 1;
    localparam int CMP_W      = SUM_W + FRAC_BITS + 1;

    logic [LEVEL_BITS-1:0]               scaled;
    logic signed [LEVEL_BITS:0]          diff;
    logic signed [ALPHA_BITS:0]          alpha_s;
    logic signed [LEVEL_BITS+ALPHA_BITS:0] prod;
    logic signed [ACC_W-1:0]             acc;
    logic [LEVEL_BITS-1:0]               smoothed;
    logic [LEVEL_BITS-1:0]               level_cur;
    logic                                in_dip_cur;
    logic [DIPS_BITS-1:0]                dips_cur;
    logic [SUM_W-1:0]                    low_sum;
    logic [CMP_W-1:0]                    low_side;
    logic [CMP_W-1:0]                    level_cmp;
    logic [CMP_W-1:0]                    rearm_cmp;
    logic                                trigger;
    logic                                rearm;

    // Exponential average: level + alpha * (sample - level), round half up
    assign scaled  = {sample, {FRAC_BITS{1'b0}}};
    assign diff    = $signed({1'b0, scaled}) - $signed({1'b0, level});
    assign alpha_s = $signed({1'b0, alpha});
    assign prod    = diff * alpha_s;
    assign acc     = $signed({2'b00, level, {ALPHA_BITS{1'b0}}})
                   + ACC_W'(prod)
                   + $signed({{(LEVEL_BITS+2){1'b0}}, 1'b1, {(ALPHA_BITS-1){1'b0}}});
    assign smoothed = acc[LEVEL_BITS+ALPHA_BITS-1:ALPHA_BITS];

    // A fresh window starts from the sample itself with cleared dip state
    always_comb
    begin
        if (win.fresh)
        begin
            level_cur  = scaled;
            in_dip_cur = 1'b0;
            dips_cur   = '0;
        end
        else
        begin
            level_cur  = smoothed;
            in_dip_cur = win.in_dip;
            dips_cur   = win.dips;
        end
    end

    // Threshold compares in full fixed point
    assign low_sum   = SUM_W'(sample) + SUM_W'(threshold);
    assign low_side  = CMP_W'({low_sum, {FRAC_BITS{1'b0}}});
    assign level_cmp = CMP_W'(level_cur);
    assign rearm_cmp = level_cmp + CMP_W'({hysteresis, {FRAC_BITS{1'b0}}});
    assign trigger   = !in_dip_cur && (low_side <= level_cmp);
    assign rearm     = in_dip_cur && (low_side >= rearm_cmp);

    // Dip flag and saturating dip count
    always_comb
    begin
        level_next      = level_cur;
        win_next.fresh  = last_of_window;
        win_next.in_dip = in_dip_cur;
        win_next.dips   = dips_cur;
        if (trigger)
        begin
            win_next.in_dip = 1'b1;
            if (dips_cur != {DIPS_BITS{1'b1}})
            begin
                win_next.dips = dips_cur + DIPS_BITS'(1);
            end
        end
        else if (rearm)
        begin
            win_next.in_dip = 1'b0;
        end
    end

endmodule

@@ src/ema_dip_detector.sv @@
`include "assert_macros.svh"

// Light-dip detector. Takes one sensor request per cycle unless in_stall holds
// it, and returns one result request per sample: an exponential average of the
// samples, a dip flag with hysteresis, the dip count of the current window, and
// saturating totals of samples and their sum since reset. A sample flagged
// last_of_window closes the window; the next sample reloads the average.
// Throughput is one sample per clock while the result side does not stall, set
// by the single multiply-add on the average feedback path. An accepted sample is
// registered, then the average, the dip logic and the totals are updated together
// into the result registers. A result waiting under stall still lets one more
// sample in. Configuration writes take effect at once and are meant to happen
// only while no request is in flight.
module ema_dip_detector #(
    parameter int SAMPLE_BITS = edd_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = edd_pkg::DEF_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [edd_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [edd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    // sample channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [SAMPLE_BITS-1:0]             sample,
    input  logic                               last_of_window,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [edd_pkg::DIPS_BITS-1:0]      dip_count,
    output logic                               dip_active,
    output logic [SAMPLE_BITS+FRAC_BITS-1:0]   smoothed_level,
    output logic [edd_pkg::COUNT_BITS-1:0]     samples_taken,
    output logic [edd_pkg::SUM_BITS-1:0]       sample_sum,
    output logic                               window_done
);
    import edd_pkg::*;

    localparam int LEVEL_BITS = SAMPLE_BITS + FRAC_BITS;

    // Configuration registers
    logic [ALPHA_BITS-1:0]  alpha_reg;
    logic [THRESH_BITS-1:0] threshold_reg;
    logic [THRESH_BITS-1:0] hysteresis_reg;

    // Input stage
    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   s1_last_reg;

    // Result stage; the running state doubles as the result payload
    logic                   out_valid_reg;
    logic [LEVEL_BITS-1:0]  level_reg;
    edd_window_t            win_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [SUM_BITS-1:0]    sum_reg;

    logic [LEVEL_BITS-1:0]  level_next;
    edd_window_t            win_next;
    logic [COUNT_BITS-1:0]  count_next;
    logic [SUM_BITS-1:0]    sum_next;
    logic [SUM_BITS:0]      sum_wide;

    logic in_take;
    logic out_take;
    logic res_free;
    logic res_load;

    // Handshake
    assign res_free = !out_valid_reg || !out_stall;
    assign res_load = s1_valid_reg && res_free;
    assign in_stall = s1_valid_reg && !res_free;
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    // Configuration writes; unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg      <= ALPHA_RESET;
            threshold_reg  <= THRESHOLD_RESET;
            hysteresis_reg <= HYSTERESIS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ALPHA:      alpha_reg      <= cfg_wdata[ALPHA_BITS-1:0];
                REG_THRESHOLD:  threshold_reg  <= cfg_wdata[THRESH_BITS-1:0];
                REG_HYSTERESIS: hysteresis_reg <= cfg_wdata[THRESH_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (res_load)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg <= sample;
            s1_last_reg   <= last_of_window;
        end
    end

    // Average and dip update
    edd_update #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_update (
        .sample         (s1_sample_reg),
        .last_of_window (s1_last_reg),
        .alpha          (alpha_reg),
        .threshold      (threshold_reg),
        .hysteresis     (hysteresis_reg),
        .level          (level_reg),
        .win            (win_reg),
        .level_next     (level_next),
        .win_next       (win_next)
    );

    // Saturating totals
    assign count_next = (count_reg != {COUNT_BITS{1'b1}}) ? count_reg + COUNT_BITS'(1)
                                                          : count_reg;
    assign sum_wide   = {1'b0, sum_reg} + (SUM_BITS+1)'(s1_sample_reg);
    assign sum_next   = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];

    // Result registers and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            level_reg      <= '0;
            win_reg.fresh  <= 1'b1;
            win_reg.in_dip <= 1'b0;
            win_reg.dips   <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
        end
        else
        begin
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
                level_reg     <= level_next;
                win_reg       <= win_next;
                count_reg     <= count_next;
                sum_reg       <= sum_next;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The fresh flag of the last result is its own last_of_window bit
    assign out_valid      = out_valid_reg;
    assign dip_count      = win_reg.dips;
    assign dip_active     = win_reg.in_dip;
    assign smoothed_level = level_reg;
    assign samples_taken  = count_reg;
    assign sample_sum     = sum_reg;
    assign window_done    = win_reg.fresh;

    // Checks
    `ASSERT_ALWAYS(a_empty_stage_takes, clk, rst_n, !s1_valid_reg |-> !in_stall)
    `ASSERT_NEXT(a_no_count_in_dip, clk, rst_n,
        res_load && !win_reg.fresh && win_reg.in_dip, win_reg.dips == $past(win_reg.dips))
    `ASSERT_NEXT(a_totals_grow, clk, rst_n, res_load,
        (count_reg >= $past(count_reg)) && (sum_reg >= $past(sum_reg)))
    `ASSERT_NEXT(a_level_bounded, clk, rst_n, res_load,
        (level_reg <= $past(level_reg)) ||
        (level_reg <= {$past(s1_sample_reg), {FRAC_BITS{1'b0}}}))

endmodule

@@ test/ema_dip_checker.sv @@
`timescale 1ns / 1ps

// Scoreboard for the dip detector: follows register writes, keeps its own copy
// of the detector state, predicts one result per accepted sample request and
// compares every accepted result request against the oldest prediction.
module ema_dip_checker #(
    parameter int SAMPLE_BITS = edd_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = edd_pkg::DEF_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [edd_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [edd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [SAMPLE_BITS-1:0]             sample,
    input  logic                               last_of_window,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [edd_pkg::DIPS_BITS-1:0]      dip_count,
    input  logic                               dip_active,
    input  logic [SAMPLE_BITS+FRAC_BITS-1:0]   smoothed_level,
    input  logic [edd_pkg::COUNT_BITS-1:0]     samples_taken,
    input  logic [edd_pkg::SUM_BITS-1:0]       sample_sum,
    input  logic                               window_done,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 results_seen
);

    import edd_pkg::*;

    localparam int LEVEL_BITS  = SAMPLE_BITS + FRAC_BITS;
    localparam int PRINT_LIMIT = 40;
    localparam logic [63:0] ALPHA_ONE = 64'd65536;
    localparam logic [DIPS_BITS-1:0]  DIPS_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;

    typedef struct packed {
        logic [DIPS_BITS-1:0]  dips;
        logic                  active;
        logic [LEVEL_BITS-1:0] level;
        logic [COUNT_BITS-1:0] count;
        logic [SUM_BITS-1:0]   sum;
        logic                  done;
    } dip_result_t;

    // register copies
    logic [ALPHA_BITS-1:0]  alpha_q;
    logic [THRESH_BITS-1:0] thresh_q;
    logic [THRESH_BITS-1:0] hyst_q;

    // detector state copy
    logic [LEVEL_BITS-1:0]  level_q;
    edd_window_t            win_q;
    logic [COUNT_BITS-1:0]  count_q;
    logic [SUM_BITS-1:0]    sum_q;

    dip_result_t expected_results[$];
    int          fails;
    int          compared;

    // Advance the detector copy by one sample and return the result it gives
    function automatic dip_result_t advance_detector(input logic [SAMPLE_BITS-1:0] s,
                                                     input logic closes);
        logic [63:0] scaled;
        logic [63:0] low_side;
        logic [63:0] acc;
        dip_result_t r;
        scaled   = 64'(s) << FRAC_BITS;
        low_side = (64'(s) + 64'(thresh_q)) << FRAC_BITS;

        // saturating totals
        if (count_q != COUNT_MAX)
        begin
            count_q = count_q + 1'b1;
        end
        if (64'(SUM_MAX - sum_q) < 64'(s))
        begin
            sum_q = SUM_MAX;
        end
        else
        begin
            sum_q = sum_q + SUM_BITS'(s);
        end

        // window start reloads the level, otherwise exponential update
        if (win_q.fresh)
        begin
            level_q      = scaled[LEVEL_BITS-1:0];
            win_q.in_dip = 1'b0;
            win_q.dips   = '0;
            win_q.fresh  = 1'b0;
        end
        else
        begin
            acc = 64'(alpha_q) * scaled + (ALPHA_ONE - 64'(alpha_q)) * 64'(level_q)
                + (ALPHA_ONE >> 1);
            level_q = acc[ALPHA_BITS +: LEVEL_BITS];
        end

        // dip trigger and re-arm with hysteresis
        if (!win_q.in_dip && low_side <= 64'(level_q))
        begin
            if (win_q.dips != DIPS_MAX)
            begin
                win_q.dips = win_q.dips + 1'b1;
            end
            win_q.in_dip = 1'b1;
        end
        else if (win_q.in_dip &&
                 low_side >= 64'(level_q) + (64'(hyst_q) << FRAC_BITS))
        begin
            win_q.in_dip = 1'b0;
        end

        if (closes)
        begin
            win_q.fresh = 1'b1;
        end

        r.dips   = win_q.dips;
        r.active = win_q.in_dip;
        r.level  = level_q;
        r.count  = count_q;
        r.sum    = sum_q;
        r.done   = closes;
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (fails < PRINT_LIMIT)
        begin
            $display("[%0t] result %0d: %s got %0h expected %0h", $time, compared, what,
                     got, want);
        end
        fails++;
    endtask

    task automatic compare_result(input dip_result_t got, input dip_result_t want);
        if (got.dips !== want.dips)
        begin
            report("dip_count", 64'(got.dips), 64'(want.dips));
        end
        if (got.active !== want.active)
        begin
            report("dip_active", 64'(got.active), 64'(want.active));
        end
        if (got.level !== want.level)
        begin
            report("smoothed_level", 64'(got.level), 64'(want.level));
        end
        if (got.count !== want.count)
        begin
            report("samples_taken", 64'(got.count), 64'(want.count));
        end
        if (got.sum !== want.sum)
        begin
            report("sample_sum", 64'(got.sum), 64'(want.sum));
        end
        if (got.done !== want.done)
        begin
            report("window_done", 64'(got.done), 64'(want.done));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dip_result_t got;
        dip_result_t want;
        if (!rst_n)
        begin
            alpha_q      = ALPHA_RESET;
            thresh_q     = THRESHOLD_RESET;
            hyst_q       = HYSTERESIS_RESET;
            level_q      = '0;
            win_q        = '0;
            win_q.fresh  = 1'b1;
            count_q      = '0;
            sum_q        = '0;
            fails        = 0;
            compared     = 0;
            expected_results.delete();
            fail_count   <= 0;
            pending      <= 0;
            results_seen <= 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_ALPHA:      alpha_q  = cfg_wdata[ALPHA_BITS-1:0];
                    REG_THRESHOLD:  thresh_q = cfg_wdata[THRESH_BITS-1:0];
                    REG_HYSTERESIS: hyst_q   = cfg_wdata[THRESH_BITS-1:0];
                    default: ;
                endcase
            end

            // result request taken
            if (out_valid && !out_stall)
            begin
                got.dips   = dip_count;
                got.active = dip_active;
                got.level  = smoothed_level;
                got.count  = samples_taken;
                got.sum    = sample_sum;
                got.done   = window_done;
                if (expected_results.size() == 0)
                begin
                    report("result with none outstanding, dip_count", 64'(got.dips), 64'(0));
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_result(got, want);
                end
                compared++;
            end

            // sample request taken
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(advance_detector(sample, last_of_window));
            end

            fail_count   <= fails;
            pending      <= expected_results.size();
            results_seen <= compared;
        end
    end

endmodule

@@ test/tb_ema_dip_detector.sv @@
`timescale 1ns / 1ps

module tb_ema_dip_detector;

    import edd_pkg::*;

    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE = 2'd3;
    localparam int TOTAL_ITEMS = 1550;
    localparam int HOLD_CYCLES = 150;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                              cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0]          cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0]          cfg_wdata = '0;

    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [DEF_SAMPLE_BITS-1:0]        sample = '0;
    logic                              last_of_window = 1'b0;

    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [DIPS_BITS-1:0]              dip_count;
    logic                              dip_active;
    logic [DEF_SAMPLE_BITS+DEF_FRAC_BITS-1:0] smoothed_level;
    logic [COUNT_BITS-1:0]             samples_taken;
    logic [SUM_BITS-1:0]               sample_sum;
    logic                              window_done;

    int fail_count;
    int pending;
    int results_seen;

    // sender / receiver knobs shared between processes
    bit idle_en = 1'b0;
    bit stall_en = 1'b0;
    bit hold_off_req = 1'b0;

    int samples_sent = 0;
    int windows_closed = 0;
    int settings_used = 0;
    int thr_eff = int'(THRESHOLD_RESET);
    int hys_eff = int'(HYSTERESIS_RESET);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ema_dip_detector dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .last_of_window (last_of_window),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .dip_count      (dip_count),
        .dip_active     (dip_active),
        .smoothed_level (smoothed_level),
        .samples_taken  (samples_taken),
        .sample_sum     (sample_sum),
        .window_done    (window_done)
    );

    ema_dip_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .last_of_window (last_of_window),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .dip_count      (dip_count),
        .dip_active     (dip_active),
        .smoothed_level (smoothed_level),
        .samples_taken  (samples_taken),
        .sample_sum     (sample_sum),
        .window_done    (window_done),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_seen   (results_seen)
    );

    // Offer one sample request, after an optional idle gap, and wait until taken
    task automatic send_sample(input int s, input bit closes);
        int gap;
        gap = idle_en ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid       <= 1'b0;
            sample         <= DEF_SAMPLE_BITS'($urandom);
            last_of_window <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        sample         <= s[DEF_SAMPLE_BITS-1:0];
        last_of_window <= closes;
        do @(posedge clk); while (in_stall);
        samples_sent++;
        if (closes)
        begin
            windows_closed++;
        end
    endtask

    // Stop offering and wait for every outstanding result, plus the pipe latency
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    // Write all registers, plus the unused index which must be ignored
    task automatic apply_settings(input logic [15:0] a, input logic [15:0] th,
                                  input logic [15:0] hy);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_ALPHA;
        cfg_wdata <= a;
        @(posedge clk);
        cfg_addr  <= REG_THRESHOLD;
        cfg_wdata <= th;
        @(posedge clk);
        cfg_addr  <= REG_HYSTERESIS;
        cfg_wdata <= hy;
        @(posedge clk);
        cfg_addr  <= REG_SPARE;
        cfg_wdata <= CFG_DATA_BITS'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
        thr_eff = int'(th[THRESH_BITS-1:0]);
        hys_eff = int'(hy[THRESH_BITS-1:0]);
        settings_used++;
    endtask

    // Result side: random stall per result, plus an occasional long hold-off
    initial
    begin : result_sink
        int n;
        forever
        begin
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            n = stall_en ? $urandom_range(0, 3) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin : stimulus
        int phase;
        int phase_len;
        int phase_items;
        int len;
        int base;
        int spread;
        int v;
        int r;
        bit noisy;
        bit closes;
        logic [15:0] a_w;
        logic [15:0] t_w;
        logic [15:0] h_w;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values: steady level, dip, hold, re-arm, second dip
        send_sample(2000, 1'b0);
        send_sample(2010, 1'b0);
        send_sample(1500, 1'b0);
        send_sample(1400, 1'b0);
        send_sample(2600, 1'b0);
        send_sample(0, 1'b0);
        send_sample(4095, 1'b1);
        drain_results();

        // zero alpha holds the level; zero threshold dips on a window's first sample
        apply_settings(16'd0, 16'd0, 16'd0);
        send_sample(4095, 1'b0);
        send_sample(0, 1'b0);
        send_sample(4095, 1'b1);
        send_sample(0, 1'b1);
        drain_results();

        // extreme registers, upper data bits set on the narrow ones
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(4095, 1'b0);
        send_sample(0, 1'b0);
        send_sample(4095, 1'b1);
        drain_results();

        // hysteresis above threshold: re-arm level above the smoothed level
        apply_settings(16'd32768, 16'd20, 16'd300);
        send_sample(3000, 1'b0);
        send_sample(2000, 1'b0);
        send_sample(2900, 1'b0);
        send_sample(4000, 1'b1);
        drain_results();

        // random phases, each under its own register setting
        phase = 0;
        while (samples_sent < TOTAL_ITEMS)
        begin
            case ($urandom_range(0, 4))
                0: a_w = 16'd0;
                1: a_w = 16'd1;
                2: a_w = 16'hFFFF;
                3: a_w = ALPHA_RESET;
                default: a_w = 16'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: t_w = 16'd0;
                1: t_w = 16'hFFFF;
                2: t_w = 16'($urandom_range(0, 300));
                default: t_w = 16'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: h_w = 16'd0;
                1: h_w = 16'hFFFF;
                2: h_w = 16'($urandom_range(0, 200));
                default: h_w = 16'($urandom);
            endcase
            apply_settings(a_w, t_w, h_w);

            // first phase runs back to back on both sides
            idle_en  = (phase != 0) && ($urandom_range(0, 3) != 0);
            stall_en = (phase != 0) && ($urandom_range(0, 3) != 0);
            if (phase == 2 || phase == 7)
            begin
                hold_off_req = 1'b1;
            end

            phase_len   = $urandom_range(90, 160);
            phase_items = 0;
            while (phase_items < phase_len && samples_sent < TOTAL_ITEMS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 24);
                noisy  = ($urandom_range(0, 9) == 0);
                base   = ($urandom_range(0, 3) != 0) ? $urandom_range(thr_eff, 4095)
                                                     : $urandom_range(0, 4095);
                spread = thr_eff / 4 + 2;
                for (int k = 0; k < len && samples_sent < TOTAL_ITEMS; k++)
                begin
                    if (noisy)
                    begin
                        // broken windows: random codes and random window ends
                        v      = $urandom_range(0, 4095);
                        closes = ($urandom_range(0, 3) == 0);
                    end
                    else
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 70)
                        begin
                            v = base + $urandom_range(0, 2 * spread) - spread;
                        end
                        else if (r < 90)
                        begin
                            v = base - thr_eff - $urandom_range(0, 40);
                        end
                        else if (r < 95)
                        begin
                            v = base - thr_eff + hys_eff + $urandom_range(0, 20);
                        end
                        else
                        begin
                            v = $urandom_range(0, 4095);
                        end
                        base   = base + $urandom_range(0, 20) - 10;
                        closes = (k == len - 1);
                    end
                    if (v < 0)
                    begin
                        v = 0;
                    end
                    else if (v > 4095)
                    begin
                        v = 4095;
                    end
                    send_sample(v, closes);
                    phase_items++;
                    // mid-phase pause until every result is back
                    if (phase % 4 == 1 && phase_items == phase_len / 2)
                    begin
                        drain_results();
                    end
                end
            end
            drain_results();
            phase++;
        end

        repeat (5) @(posedge clk);
        $display("checked %0d samples over %0d closed windows and %0d register settings",
                 samples_sent, windows_closed, settings_used);
        $display("%0d results compared, with long output hold-offs and mid-window drains",
                 results_seen);
        if (fail_count == 0)
        begin
            $display("ema_dip_detector regression: pass");
        end
        else
        begin
            $display("ema_dip_detector regression: fail");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("timeout with %0d results outstanding", pending);
        $display("ema_dip_detector regression: fail");
        $finish;
    end

endmodule
